// ===== rtl/rntt_pkg.sv =====
// shared constants, payload types, command/status structs for the ntt block
// no dependencies
package rntt_pkg;

    localparam int POINTS     = 64;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_BITS  = $clog2(POINTS);
    localparam int STAGES     = ADDR_BITS;
    localparam int BFLY_BITS  = ADDR_BITS - 1;
    localparam int STAGE_BITS = $clog2(STAGES + 1);
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int STEP_BITS  = $clog2(PROD_BITS);
    localparam int CFG_INDEX_BITS = 2;

    typedef struct packed {
        logic [VALUE_BITS-1:0] coefficient;
        logic [VALUE_BITS-1:0] twiddle;
    } load_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } result_item_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODULUS  = 2'd0,
        CFG_INV_SIZE = 2'd1,
        CFG_INV_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MR_COEF = 2'd0,
        MR_TWID = 2'd1,
        MR_PROD = 2'd2
    } mr_src_t;

    typedef enum logic [1:0] {
        WSEL_LOAD = 2'd0,
        WSEL_SUM  = 2'd1,
        WSEL_DIFF = 2'd2
    } wsel_t;

    typedef enum logic {
        PROD_BUTTERFLY = 1'b0,
        PROD_SCALE     = 1'b1
    } prod_sel_t;

    typedef enum logic {
        OUT_DIRECT  = 1'b0,
        OUT_REDUCED = 1'b1
    } out_sel_t;

    typedef struct packed {
        logic                 cap_in;
        logic                 mr_start;
        mr_src_t              mr_src;
        logic                 coef_we;
        logic [ADDR_BITS-1:0] coef_waddr;
        wsel_t                coef_wsel;
        logic                 tw_we;
        logic [ADDR_BITS-1:0] tw_waddr;
        logic [ADDR_BITS-1:0] coef_raddr;
        logic [ADDR_BITS-1:0] tw_raddr;
        logic                 cap_b;
        logic                 cap_a;
        logic                 cap_prod;
        prod_sel_t            prod_sel;
        logic                 out_set;
        out_sel_t             out_sel;
        logic                 out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic mr_busy;
        logic mr_done;
        logic result_busy;
        logic inverse_mode;
    } dp_status_t;

    function automatic logic [ADDR_BITS-1:0] bit_reverse(input logic [ADDR_BITS-1:0] x);
        logic [ADDR_BITS-1:0] r;
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            r[i] = x[ADDR_BITS-1-i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rntt_modred.sv =====
// bit-serial remainder unit: operand mod modulus, one quotient bit per cycle
// depends on rntt_pkg
module rntt_modred
    import rntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PROD_BITS-1:0]  operand,
    input  logic [VALUE_BITS-1:0] modulus,
    output logic                  busy,
    output logic                  done,
    output logic [VALUE_BITS-1:0] remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_BITS-1:0]  cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]  x_reg, x_next;
    logic [VALUE_BITS-1:0] r_reg, r_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   trial_sub;

    assign trial     = {r_reg, x_reg[PROD_BITS-1]};
    assign trial_sub = trial - {1'b0, q_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = operand;
            r_next    = '0;
            q_next    = modulus;
        end
        else if (busy_reg)
        begin
            x_next   = {x_reg[PROD_BITS-2:0], 1'b0};
            r_next   = (trial >= {1'b0, q_reg}) ? trial_sub[VALUE_BITS-1:0]
                                                : trial[VALUE_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_BITS'(PROD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    // a modulus below two reduces everything to zero
    assign remainder = (q_reg[VALUE_BITS-1:1] == '0) ? '0 : r_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

// ===== rtl/rntt_datapath.sv =====
// datapath: config registers, coefficient and twiddle memories, multiplier,
// butterfly add/subtract and result register; depends on rntt_pkg, rntt_modred
module rntt_datapath
    import rntt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  load_item_t                load_item,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VALUE_BITS-1:0]     cfg_data,
    output logic                      result_valid,
    input  logic                      result_ready,
    output result_item_t              result_item
);

    logic [VALUE_BITS-1:0] modulus_reg;
    logic [VALUE_BITS-1:0] inv_size_reg;
    logic                  inv_mode_reg;

    logic [VALUE_BITS-1:0] coef_mem [POINTS];
    logic [VALUE_BITS-1:0] tw_mem   [POINTS];
    logic [VALUE_BITS-1:0] coef_rdata_reg;
    logic [VALUE_BITS-1:0] tw_rdata_reg;

    logic [VALUE_BITS-1:0] coef_in_reg, tw_in_reg;
    logic [VALUE_BITS-1:0] a_reg, b_reg, w_reg;
    logic [PROD_BITS-1:0]  prod_reg;

    logic                  result_valid_reg;
    result_item_t          result_item_reg;

    logic [PROD_BITS-1:0]  mr_operand;
    logic                  mr_busy, mr_done;
    logic [VALUE_BITS-1:0] mr_rem;
    logic [VALUE_BITS:0]   sum_raw, diff_raw, sum_red, diff_red;
    logic [VALUE_BITS-1:0] coef_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= VALUE_BITS'(17);
            inv_size_reg <= VALUE_BITS'(1);
            inv_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODULUS:  modulus_reg  <= cfg_data;
                CFG_INV_SIZE: inv_size_reg <= cfg_data;
                CFG_INV_MODE: inv_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.mr_src)
            MR_COEF: mr_operand = PROD_BITS'(coef_in_reg);
            MR_TWID: mr_operand = PROD_BITS'(tw_in_reg);
            MR_PROD: mr_operand = prod_reg;
            default: mr_operand = prod_reg;
        endcase
    end

    rntt_modred u_modred (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mr_start),
        .operand   (mr_operand),
        .modulus   (modulus_reg),
        .busy      (mr_busy),
        .done      (mr_done),
        .remainder (mr_rem)
    );

    // both operands are below q, so one conditional subtract finishes the reduction
    assign sum_raw  = {1'b0, a_reg} + {1'b0, mr_rem};
    assign diff_raw = {1'b0, a_reg} + {1'b0, modulus_reg} - {1'b0, mr_rem};
    assign sum_red  = (sum_raw  >= {1'b0, modulus_reg}) ? sum_raw  - {1'b0, modulus_reg}
                                                        : sum_raw;
    assign diff_red = (diff_raw >= {1'b0, modulus_reg}) ? diff_raw - {1'b0, modulus_reg}
                                                        : diff_raw;

    always_comb
    begin
        case (cmd.coef_wsel)
            WSEL_LOAD: coef_wdata = mr_rem;
            WSEL_SUM:  coef_wdata = sum_red[VALUE_BITS-1:0];
            WSEL_DIFF: coef_wdata = diff_red[VALUE_BITS-1:0];
            default:   coef_wdata = mr_rem;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_we)
        begin
            coef_mem[cmd.coef_waddr] <= coef_wdata;
        end
        if (cmd.tw_we)
        begin
            tw_mem[cmd.tw_waddr] <= mr_rem;
        end
        coef_rdata_reg <= coef_mem[cmd.coef_raddr];
        tw_rdata_reg   <= tw_mem[cmd.tw_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            coef_in_reg <= load_item.coefficient;
            tw_in_reg   <= load_item.twiddle;
        end
        if (cmd.cap_b)
        begin
            b_reg <= coef_rdata_reg;
            w_reg <= tw_rdata_reg;
        end
        if (cmd.cap_a)
        begin
            a_reg <= coef_rdata_reg;
        end
        if (cmd.cap_prod)
        begin
            case (cmd.prod_sel)
                PROD_BUTTERFLY: prod_reg <= b_reg * w_reg;
                PROD_SCALE:     prod_reg <= a_reg * inv_size_reg;
                default:        prod_reg <= b_reg * w_reg;
            endcase
        end
        if (cmd.out_set)
        begin
            result_item_reg.value <= (cmd.out_sel == OUT_REDUCED) ? mr_rem : a_reg;
            result_item_reg.last  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_set)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid        = result_valid_reg;
    assign result_item         = result_item_reg;
    assign status.mr_busy      = mr_busy;
    assign status.mr_done      = mr_done;
    assign status.result_busy  = result_valid_reg;
    assign status.inverse_mode = inv_mode_reg;

    a_mr_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mr_start |-> !mr_busy)
        else $error("reduction started while busy");

    a_mr_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mr_done |-> !mr_busy)
        else $error("reduction done while still busy");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_set |-> !result_valid_reg)
        else $error("result register overwritten");

endmodule

// ===== rtl/rntt_ctrl.sv =====
// controller state machine: load sequencing, butterfly scheduling, output drain
// depends on rntt_pkg
module rntt_ctrl
    import rntt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_valid,
    output logic       load_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_LD_C     = 12'b000000000010,
        S_LD_C_W   = 12'b000000000100,
        S_LD_T_W   = 12'b000000001000,
        S_BF_RDB   = 12'b000000010000,
        S_BF_RDA   = 12'b000000100000,
        S_BF_MUL   = 12'b000001000000,
        S_BF_RED   = 12'b000010000000,
        S_BF_WAIT  = 12'b000100000000,
        S_BF_WR1   = 12'b001000000000,
        S_OUT_RD   = 12'b010000000000,
        S_OUT_CAP  = 12'b100000000000
    } state_t;

    typedef enum logic [4:0] {
        O_NONE = 5'b00001,
        O_MUL  = 5'b00010,
        O_RED  = 5'b00100,
        O_WAIT = 5'b01000,
        O_PUT  = 5'b10000
    } out_phase_t;

    state_t                state_reg, state_next;
    out_phase_t            oph_reg, oph_next;
    logic [ADDR_BITS-1:0]  idx_reg, idx_next;
    logic [BFLY_BITS-1:0]  bf_reg, bf_next;
    logic [STAGE_BITS-1:0] stage_reg, stage_next;

    logic [ADDR_BITS-1:0]  bf_ext, half_mask, half_bit, k_lo, k_up, tw_idx;

    // butterfly c of a stage: k = group*span + j, twiddle index = j * stride
    assign bf_ext    = ADDR_BITS'(bf_reg);
    assign half_bit  = ADDR_BITS'(1) << stage_reg;
    assign half_mask = half_bit - ADDR_BITS'(1);
    assign k_lo      = ((bf_ext & ~half_mask) << 1) | (bf_ext & half_mask);
    assign k_up      = k_lo | half_bit;
    assign tw_idx    = (bf_ext & half_mask) << (STAGE_BITS'(STAGES - 1) - stage_reg);

    always_comb
    begin
        state_next = state_reg;
        oph_next   = oph_reg;
        idx_next   = idx_reg;
        bf_next    = bf_reg;
        stage_next = stage_reg;
        load_ready = 1'b0;
        cmd        = '0;
        cmd.mr_src    = MR_PROD;
        cmd.coef_wsel = WSEL_LOAD;
        cmd.prod_sel  = PROD_BUTTERFLY;
        cmd.out_sel   = OUT_DIRECT;
        case (state_reg)
            S_IDLE:
            begin
                load_ready = 1'b1;
                if (load_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = S_LD_C;
                end
            end
            S_LD_C:
            begin
                cmd.mr_start = 1'b1;
                cmd.mr_src   = MR_COEF;
                state_next   = S_LD_C_W;
            end
            S_LD_C_W:
            begin
                // coefficients land at bit-reversed addresses
                cmd.coef_waddr = bit_reverse(idx_reg);
                if (status.mr_done)
                begin
                    cmd.coef_we  = 1'b1;
                    cmd.mr_start = 1'b1;
                    cmd.mr_src   = MR_TWID;
                    state_next   = S_LD_T_W;
                end
            end
            S_LD_T_W:
            begin
                cmd.tw_waddr = idx_reg;
                if (status.mr_done)
                begin
                    cmd.tw_we = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    if (idx_reg == ADDR_BITS'(POINTS - 1))
                    begin
                        bf_next    = '0;
                        stage_next = '0;
                        state_next = S_BF_RDB;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BF_RDB:
            begin
                cmd.coef_raddr = k_up;
                cmd.tw_raddr   = tw_idx;
                state_next     = S_BF_RDA;
            end
            S_BF_RDA:
            begin
                cmd.coef_raddr = k_lo;
                cmd.cap_b      = 1'b1;
                state_next     = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                cmd.cap_a    = 1'b1;
                cmd.cap_prod = 1'b1;
                state_next   = S_BF_RED;
            end
            S_BF_RED:
            begin
                cmd.mr_start = 1'b1;
                state_next   = S_BF_WAIT;
            end
            S_BF_WAIT:
            begin
                cmd.coef_waddr = k_lo;
                cmd.coef_wsel  = WSEL_SUM;
                if (status.mr_done)
                begin
                    cmd.coef_we = 1'b1;
                    state_next  = S_BF_WR1;
                end
            end
            S_BF_WR1:
            begin
                cmd.coef_we    = 1'b1;
                cmd.coef_waddr = k_up;
                cmd.coef_wsel  = WSEL_DIFF;
                bf_next        = bf_reg + 1'b1;
                state_next     = S_BF_RDB;
                if (bf_reg == BFLY_BITS'(POINTS / 2 - 1))
                begin
                    stage_next = stage_reg + 1'b1;
                    if (stage_reg == STAGE_BITS'(STAGES - 1))
                    begin
                        idx_next   = '0;
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD:
            begin
                cmd.coef_raddr = idx_reg;
                state_next     = S_OUT_CAP;
            end
            S_OUT_CAP:
            begin
                case (oph_reg)
                    O_NONE:
                    begin
                        cmd.cap_a = 1'b1;
                        oph_next  = status.inverse_mode ? O_MUL : O_PUT;
                    end
                    O_MUL:
                    begin
                        cmd.cap_prod = 1'b1;
                        cmd.prod_sel = PROD_SCALE;
                        oph_next     = O_RED;
                    end
                    O_RED:
                    begin
                        cmd.mr_start = 1'b1;
                        oph_next     = O_WAIT;
                    end
                    O_WAIT:
                    begin
                        if (status.mr_done)
                        begin
                            oph_next = O_PUT;
                        end
                    end
                    O_PUT:
                    begin
                        cmd.out_sel  = status.inverse_mode ? OUT_REDUCED : OUT_DIRECT;
                        cmd.out_last = (idx_reg == ADDR_BITS'(POINTS - 1));
                        if (!status.result_busy)
                        begin
                            cmd.out_set = 1'b1;
                            oph_next    = O_NONE;
                            idx_next    = idx_reg + 1'b1;
                            state_next  = (idx_reg == ADDR_BITS'(POINTS - 1)) ? S_IDLE
                                                                               : S_OUT_RD;
                        end
                    end
                    default:
                    begin
                        oph_next = O_NONE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oph_reg   <= O_NONE;
            idx_reg   <= '0;
            bf_reg    <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            oph_reg   <= oph_next;
            idx_reg   <= idx_next;
            bf_reg    <= bf_next;
            stage_reg <= stage_next;
        end
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_ready |-> !status.mr_busy)
        else $error("load request taken during a reduction");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.coef_we && cmd.tw_we))
        else $error("both stores written at once");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BF_RDB) |-> (stage_reg < STAGE_BITS'(STAGES)))
        else $error("butterfly stage out of range");

endmodule

// ===== rtl/radix2_number_theoretic_transform_top.sv =====
// radix-2 number theoretic transform, top level
// depends on rntt_pkg, rntt_ctrl, rntt_datapath
//
// usage:
//   load channel (load_valid/load_ready/load_item): one request per point carries a
//   coefficient and the twiddle entry at the same index; both are reduced mod q
//   by a bit-serial remainder unit (accept, start, two reductions); the next request
//   is accepted only after both reductions have finished.
//   after the 64th request the block runs 6 stages of 32 butterflies; each
//   butterfly reads b, w and a from memory, runs one bit-serial reduction of w*b and
//   makes two write-backs on the single coefficient write port.
//   result channel (result_valid/result_ready/result_item): 64 values in index
//   order, last flagged on the 64th; in inverse mode each value is first scaled
//   by the inverse of size and reduced mod q.
//   config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready:
//   index 0 modulus, 1 inverse of size, 2 inverse mode; other indexes ignored.
//   reset returns modulus 17, inverse of size 1, forward mode, load count zero;
//   stores are left as they are.
//   a stalled receiver holds the result register and pauses the output sequence.
module radix2_number_theoretic_transform_top
    import rntt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_valid,
    output logic                      load_ready,
    input  load_item_t                load_item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output result_item_t              result_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VALUE_BITS-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rntt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rntt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .load_item    (load_item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule
